// ===== hw/rtl/fre_pkg.sv =====
// fre_pkg: shared types and constants of the frame rotation engine.
// Used by fre_ctrl and frame_rotation_engine; depends on nothing.
package fre_pkg;

  localparam int CFG_DW = 9;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;

  localparam logic [CFG_DW-1:0] IMG_WIDTH_RST  = 9'd256;
  localparam logic [CFG_DW-1:0] IMG_HEIGHT_RST = 9'd256;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_IMG_WIDTH   = 2'd0,
    REG_IMG_HEIGHT  = 2'd1,
    REG_ROTATE_MODE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ROT_90  = 1'b0,
    ROT_180 = 1'b1
  } rot_t;

  typedef struct packed {
    logic [CFG_DW-1:0] img_width;
    logic [CFG_DW-1:0] img_height;
    rot_t              rotate_mode;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic err;
  } rsp_t;

endpackage

// ===== hw/rtl/fre_ram.sv =====
// fre_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module fre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/fre_ctrl.sv =====
// fre_ctrl: load and fetch position counters, frame-full flag and
// frame store address generation. Depends on fre_pkg.
module fre_ctrl
  import fre_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  op_t           op,
  input  cfg_t          cfg,
  output logic          mem_we,
  output logic          mem_re,
  output logic [AW-1:0] mem_addr,
  output rsp_t          rsp
);

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int KW   = (MAXD > 1) ? $clog2(MAXD) : 1;

  logic [KW-1:0] load_col, load_row, read_col, read_row;
  logic [KW-1:0] load_col_next, load_row_next, read_col_next, read_row_next;
  logic          frame_full, frame_full_next;

  logic [31:0] w32, h32, out_w, out_h;
  logic [31:0] lc, lr, rc, rr, lc1, lr1, rc1, rr1;
  logic [31:0] src_row, src_col, load_addr, fetch_addr;
  logic        is_load, is_fetch, wrap;

  always_comb begin
    w32 = 32'(cfg.img_width);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end
    h32 = 32'(cfg.img_height);
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end
    out_w = (cfg.rotate_mode == ROT_180) ? w32 : h32;
    out_h = (cfg.rotate_mode == ROT_180) ? h32 : w32;

    // counters left outside the frame by a size change restart at zero
    if (32'(load_col) >= w32 || 32'(load_row) >= h32) begin
      lc = 32'd0;
      lr = 32'd0;
    end else begin
      lc = 32'(load_col);
      lr = 32'(load_row);
    end
    if (32'(read_col) >= out_w || 32'(read_row) >= out_h) begin
      rc = 32'd0;
      rr = 32'd0;
    end else begin
      rc = 32'(read_col);
      rr = 32'(read_row);
    end

    if (cfg.rotate_mode == ROT_180) begin
      src_row = h32 - 32'd1 - rr;
      src_col = w32 - 32'd1 - rc;
    end else begin
      src_row = h32 - 32'd1 - rc;
      src_col = rr;
    end
    load_addr  = lr * 32'(MAX_WIDTH) + lc;
    fetch_addr = src_row * 32'(MAX_WIDTH) + src_col;

    is_load  = accept && (op == OP_LOAD) && !frame_full;
    is_fetch = accept && (op == OP_FETCH) && frame_full;

    lc1 = lc + 32'd1;
    lr1 = lr;
    if (lc1 >= w32) begin
      lc1 = 32'd0;
      lr1 = lr + 32'd1;
    end
    rc1  = rc + 32'd1;
    rr1  = rr;
    wrap = 1'b0;
    if (rc1 >= out_w) begin
      rc1 = 32'd0;
      rr1 = rr + 32'd1;
      if (rr1 >= out_h) begin
        rr1  = 32'd0;
        wrap = 1'b1;
      end
    end

    load_col_next   = load_col;
    load_row_next   = load_row;
    read_col_next   = read_col;
    read_row_next   = read_row;
    frame_full_next = frame_full;
    if (is_load) begin
      load_col_next = lc1[KW-1:0];
      load_row_next = lr1[KW-1:0];
      if (lr1 >= h32) begin
        load_row_next   = '0;
        frame_full_next = 1'b1;
      end
    end
    if (is_fetch) begin
      read_col_next = rc1[KW-1:0];
      read_row_next = rr1[KW-1:0];
      if (wrap) begin
        frame_full_next = 1'b0;
        load_col_next   = '0;
        load_row_next   = '0;
      end
    end

    mem_we    = is_load;
    mem_re    = is_fetch;
    mem_addr  = is_load ? load_addr[AW-1:0] : fetch_addr[AW-1:0];
    rsp.valid = accept && (op == OP_FETCH);
    rsp.last  = is_fetch && wrap;
    rsp.err   = !frame_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col   <= '0;
      load_row   <= '0;
      read_col   <= '0;
      read_row   <= '0;
      frame_full <= 1'b0;
    end else begin
      load_col   <= load_col_next;
      load_row   <= load_row_next;
      read_col   <= read_col_next;
      read_row   <= read_row_next;
      frame_full <= frame_full_next;
    end
  end

endmodule

// ===== hw/rtl/frame_rotation_engine.sv =====
// frame_rotation_engine: stores one RGB frame, returns it rotated 90 or 180 degrees.
// A fetch result appears on done in the cycle after the item is accepted.
// Throughput: one item per cycle, loads and fetches alike; each makes at most one access
// to the single-port frame store. busy stays low; the receiver cannot stall.
// Reset: synchronous; counters and frame-full clear, registers return to
// 256 x 256, 90 degrees. Frame store contents are not cleared.
module frame_rotation_engine
  import fre_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [CH_W-1:0]   red_in,
  input  logic [CH_W-1:0]   green_in,
  input  logic [CH_W-1:0]   blue_in,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output logic              done,
  output logic [CH_W-1:0]   red_out,
  output logic [CH_W-1:0]   green_out,
  output logic [CH_W-1:0]   blue_out,
  output logic              last_pixel,
  output logic              status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t             cfg;
  rsp_t             rsp;
  logic             accept;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [PIX_W-1:0] wdata, rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wdata  = {red_in, green_in, blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_width   <= IMG_WIDTH_RST;
      cfg.img_height  <= IMG_HEIGHT_RST;
      cfg.rotate_mode <= ROT_90;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMG_WIDTH:   cfg.img_width   <= cfg_data;
        REG_IMG_HEIGHT:  cfg.img_height  <= cfg_data;
        REG_ROTATE_MODE: cfg.rotate_mode <= rot_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  fre_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op_t'(opcode)),
    .cfg      (cfg),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .rsp      (rsp)
  );

  fre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      last_pixel <= 1'b0;
      status     <= 1'b0;
    end else begin
      done       <= rsp.valid;
      last_pixel <= rsp.valid && rsp.last;
      status     <= rsp.valid && rsp.err;
    end
  end

  assign red_out   = status ? '0 : rdata[3*CH_W-1:2*CH_W];
  assign green_out = status ? '0 : rdata[2*CH_W-1:CH_W];
  assign blue_out  = status ? '0 : rdata[CH_W-1:0];

  a_done_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (opcode == OP_FETCH)))
    else $error("result without a fetch item");

  a_last_not_error: assert property (@(posedge clk) disable iff (rst)
    done |-> !(last_pixel && status))
    else $error("last pixel flagged on an error result");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (rst)
    (done && last_pixel) |=> (!done || status))
    else $error("fetch after last pixel did not see an empty frame");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("frame store read and write in one cycle");

endmodule
